/* hw/rtl/abr_pkg.sv */
// shared constants, types and command/status structs of the alternating-bit receiver
`timescale 1ns / 1ps

package abr_pkg;

  localparam int PAYLOAD_BYTES = 20;
  localparam int BYTE_W        = 8;
  localparam int WORD_W        = 32;
  localparam int CNT_W         = $clog2(PAYLOAD_BYTES + 1);
  localparam int IDX_W         = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
  // signed running sum of up to PAYLOAD_BYTES bytes of -128..127
  localparam int SUM_W         = $clog2(PAYLOAD_BYTES * 128 + 1) + 1;

  localparam logic [WORD_W-1:0] PURE_ACK_SEQ = '1;

  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_ACK  = 1'b1;

  typedef struct packed {
    logic take;       // input side open
    logic judge;      // evaluate checksum and sequence of the closed packet
    logic load_data;  // move next stored byte into the output register
    logic load_ack;   // move the ack into the output register, restart packet
  } abr_cmd_t;

  typedef struct packed {
    logic in_fire;    // input word taken this cycle
    logic in_last;    // taken word closes the packet
    logic pass;       // closed packet is good and in sequence
    logic has_bytes;  // packet holds at least one stored byte
    logic rd_last;    // replay index sits on the last stored byte
    logic out_free;   // output register can take a word this cycle
  } abr_sts_t;

endpackage

/* hw/rtl/abr_in_if.sv */
// input channel of the alternating-bit receiver
`timescale 1ns / 1ps

interface abr_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [abr_pkg::BYTE_W-1:0]  payload_byte;
  logic signed [abr_pkg::WORD_W-1:0]  rx_seq;
  logic signed [abr_pkg::WORD_W-1:0]  rx_ack;
  logic signed [abr_pkg::WORD_W-1:0]  rx_check;
  logic                               end_of_packet;

  modport source (output valid, payload_byte, rx_seq, rx_ack, rx_check, end_of_packet,
                  input ready);
  modport sink   (input valid, payload_byte, rx_seq, rx_ack, rx_check, end_of_packet,
                  output ready);
endinterface

/* hw/rtl/abr_out_if.sv */
// result channel of the alternating-bit receiver
`timescale 1ns / 1ps

interface abr_out_if;
  logic                               valid;
  logic                               ready;
  logic                               kind;
  logic signed [abr_pkg::BYTE_W-1:0]  out_byte;
  logic                               ack_bit;
  logic                               run_end;

  modport source (output valid, kind, out_byte, ack_bit, run_end, input ready);
  modport sink   (input valid, kind, out_byte, ack_bit, run_end, output ready);
endinterface

/* hw/rtl/abr_ctrl.sv */
// controller state machine: collect, judge, replay, ack
`timescale 1ns / 1ps

module abr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  abr_pkg::abr_sts_t sts,
  output abr_pkg::abr_cmd_t cmd
);
  import abr_pkg::*;

  typedef enum logic [1:0] {
    ST_COLLECT,
    ST_JUDGE,
    ST_REPLAY,
    ST_ACK
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      ST_COLLECT: begin
        cmd.take = 1'b1;
        if (sts.in_fire && sts.in_last) begin
          state_nxt = ST_JUDGE;
        end
      end
      ST_JUDGE: begin
        cmd.judge = 1'b1;
        if (sts.pass && sts.has_bytes) begin
          state_nxt = ST_REPLAY;
        end else begin
          state_nxt = ST_ACK;
        end
      end
      ST_REPLAY: begin
        if (sts.out_free) begin
          cmd.load_data = 1'b1;
          if (sts.rd_last) begin
            state_nxt = ST_ACK;
          end
        end
      end
      ST_ACK: begin
        if (sts.out_free) begin
          cmd.load_ack = 1'b1;
          state_nxt    = ST_COLLECT;
        end
      end
      default: state_nxt = ST_COLLECT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_COLLECT;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_single_load: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.load_data && cmd.load_ack))
    else $error("data and ack loaded together");

  a_replay_has_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_REPLAY) |-> sts.has_bytes)
    else $error("replay of an empty packet");

  a_judge_after_close: assert property (@(posedge clk) disable iff (!rst_n)
    (sts.in_fire && sts.in_last) |=> cmd.judge)
    else $error("closing word not followed by judge");

endmodule

/* hw/rtl/abr_datapath.sv */
// byte store, running sum, check compare, expected bit and output register
`timescale 1ns / 1ps

module abr_datapath (
  input  logic              clk,
  input  logic              rst_n,
  input  abr_pkg::abr_cmd_t cmd,
  output abr_pkg::abr_sts_t sts,
  abr_in_if.sink            in_chan,
  abr_out_if.source         out_chan
);
  import abr_pkg::*;

  logic [BYTE_W-1:0]       store_r [PAYLOAD_BYTES];
  logic signed [SUM_W-1:0] sum_r;
  logic [CNT_W-1:0]        count_r;
  logic [IDX_W-1:0]        rd_idx_r;
  logic                    expected_bit_r;
  logic [WORD_W-1:0]       seq_r;
  logic [WORD_W-1:0]       ack_r;
  logic [WORD_W-1:0]       chk_r;

  logic                    out_valid_r;
  logic                    kind_r;
  logic [BYTE_W-1:0]       out_byte_r;
  logic                    ack_bit_r;
  logic                    run_end_r;

  logic                    fire;
  logic                    room;
  logic [WORD_W-1:0]       check_val;
  logic                    pass;

  assign in_chan.ready = cmd.take;
  assign fire          = in_chan.valid && cmd.take;
  assign room          = (count_r < CNT_W'(PAYLOAD_BYTES));

  // check value wraps modulo 2^32
  assign check_val = (seq_r == PURE_ACK_SEQ) ? ack_r
                   : seq_r + ack_r + WORD_W'(sum_r);
  assign pass = (check_val == chk_r) && (seq_r == WORD_W'(expected_bit_r));

  assign sts.in_fire   = fire;
  assign sts.in_last   = in_chan.end_of_packet;
  assign sts.pass      = pass;
  assign sts.has_bytes = (count_r != '0);
  assign sts.rd_last   = ((CNT_W'(rd_idx_r) + CNT_W'(1)) == count_r);
  assign sts.out_free  = !out_valid_r || out_chan.ready;

  // packet collection, expected bit and replay index
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r          <= '0;
      count_r        <= '0;
      rd_idx_r       <= '0;
      expected_bit_r <= 1'b0;
    end else begin
      if (fire && room) begin
        sum_r   <= sum_r + SUM_W'(in_chan.payload_byte);
        count_r <= count_r + CNT_W'(1);
      end
      if (cmd.judge && pass) begin
        expected_bit_r <= ~expected_bit_r;
      end
      if (cmd.load_data) begin
        rd_idx_r <= rd_idx_r + IDX_W'(1);
      end
      if (cmd.load_ack) begin
        sum_r    <= '0;
        count_r  <= '0;
        rd_idx_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && room) begin
      store_r[count_r[IDX_W-1:0]] <= in_chan.payload_byte;
    end
    if (fire && in_chan.end_of_packet) begin
      seq_r <= in_chan.rx_seq;
      ack_r <= in_chan.rx_ack;
      chk_r <= in_chan.rx_check;
    end
  end

  // output register, doubles as the registered store read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_data || cmd.load_ack) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_data) begin
      kind_r     <= KIND_DATA;
      out_byte_r <= store_r[rd_idx_r];
      ack_bit_r  <= 1'b0;
      run_end_r  <= 1'b0;
    end else if (cmd.load_ack) begin
      kind_r     <= KIND_ACK;
      out_byte_r <= '0;
      ack_bit_r  <= ~expected_bit_r;
      run_end_r  <= 1'b1;
    end
  end

  assign out_chan.valid    = out_valid_r;
  assign out_chan.kind     = kind_r;
  assign out_chan.out_byte = out_byte_r;
  assign out_chan.ack_bit  = ack_bit_r;
  assign out_chan.run_end  = run_end_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(PAYLOAD_BYTES))
    else $error("byte count past store depth");

  a_toggle_on_judge: assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(expected_bit_r) |-> $past(cmd.judge))
    else $error("expected bit moved outside judge");

  a_run_end_is_ack: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (run_end_r == (kind_r == KIND_ACK)))
    else $error("run end flag on a data word");

endmodule

/* hw/rtl/alternating_bit_receiver_core.sv */
// top level of the alternating-bit protocol receiver
`timescale 1ns / 1ps

// channel    dir   handshake       payload
// in_chan    in    valid/ready     payload_byte, rx_seq, rx_ack, rx_check, end_of_packet
// out_chan   out   valid/ready     kind, out_byte, ack_bit, run_end
//
// one input word per cycle while collecting; the closing word moves the core to the judge state
// a good packet with stored bytes then replays them one by one and ends in an ack;
// a rejected or empty packet goes straight to the ack; input is taken again only after the ack is loaded
// replay and ack advance only when the output register is free or being drained
// rst_n synchronous active low: expected bit 0, empty packet, no result pending
// the byte store holds no reset and is read only where the packet wrote it

module alternating_bit_receiver_core (
  input  logic      clk,
  input  logic      rst_n,
  abr_in_if.sink    in_chan,
  abr_out_if.source out_chan
);
  import abr_pkg::*;

  abr_cmd_t cmd;   // controller to datapath
  abr_sts_t sts;   // datapath to controller

  // sequencing of collect, judge, replay and ack
  abr_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .cmd   (cmd)
  );

  // storage, checksum and the output word register
  abr_datapath u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .sts      (sts),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

endmodule

/* dv/tb_top.sv */
// self-checking testbench for the alternating-bit receiver core
`timescale 1ns / 1ps

module tb_top;
  import abr_pkg::*;

  localparam int CLK_HALF     = 5;
  localparam int RESET_CYCLES = 5;
  // cycles without any word moving on either channel before the run is abandoned
  localparam int STALL_LIMIT  = 20000;
  // extra cycles the core is given to settle once no result is due
  localparam int DRAIN_CYCLES = 50;
  localparam int HOLD_CYCLES  = 400;

  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_SRC,
    IDLE_SINK,
    IDLE_BOTH
  } idle_mode_t;

  // how the closing word of a packet is formed
  typedef enum logic [2:0] {
    PKT_GOOD,       // right sequence, right checksum
    PKT_BAD_CHECK,  // right sequence, one checksum bit flipped
    PKT_STALE_SEQ,  // duplicate: the bit already accepted, right checksum
    PKT_PURE_ACK,   // sequence -1, checksum equal to the ack number
    PKT_ODD_SEQ     // sequence neither 0, 1 nor -1, right checksum
  } pkt_form_t;

  typedef struct packed {
    logic              kind;
    logic [BYTE_W-1:0] data;
    logic              ack_bit;
    logic              run_end;
  } result_t;

  typedef logic [BYTE_W-1:0] byte_q_t[$];

  logic clk;
  logic rst_n;

  abr_in_if  in_if ();
  abr_out_if out_if ();

  alternating_bit_receiver_core u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  idle_mode_t idle_mode    = IDLE_NONE;
  int         hold_seq     = 0;   // bumped by a test to start one long receiver hold-off
  int         errors       = 0;
  int         quiet_cycles = 0;

  // receiver state as the testbench sees it, updated on every accepted word
  logic              rx_expect_bit;
  logic [BYTE_W-1:0] byte_mem[PAYLOAD_BYTES];
  logic [WORD_W-1:0] byte_total;
  int                byte_cnt;
  result_t           results_due[$];

  // sequence bit the stimulus side believes the core is waiting for
  logic tx_bit = 1'b0;

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // predictor: stores and sums each byte, judges the packet on its closing word
  // ---------------------------------------------------------------------------
  task automatic predict_word(input logic [BYTE_W-1:0] b, input logic eop,
                              input logic [WORD_W-1:0] seq, input logic [WORD_W-1:0] ack,
                              input logic [WORD_W-1:0] chk);
    logic [WORD_W-1:0] check;
    result_t           r;
    // bytes past the store size are dropped, the closing one included
    if (byte_cnt < PAYLOAD_BYTES) begin
      byte_mem[byte_cnt] = b;
      byte_total         = byte_total + {{(WORD_W-BYTE_W){b[BYTE_W-1]}}, b};
      byte_cnt++;
    end
    if (eop) begin
      // pure ack covers only its ack number; data packets wrap modulo 2^32
      if (seq == PURE_ACK_SEQ) check = ack;
      else check = seq + ack + byte_total;
      if (check == chk && seq == {{(WORD_W-1){1'b0}}, rx_expect_bit}) begin
        for (int i = 0; i < byte_cnt; i++) begin
          r = '{KIND_DATA, byte_mem[i], 1'b0, 1'b0};
          results_due.push_back(r);
        end
        rx_expect_bit = ~rx_expect_bit;
      end
      // the ack always follows and names the last accepted bit
      r = '{KIND_ACK, '0, ~rx_expect_bit, 1'b1};
      results_due.push_back(r);
      byte_total = '0;
      byte_cnt   = 0;
    end
  endtask

  task automatic report_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
    $display("mismatch at %0t: %s expected %0h got %0h", $time, what, want, got);
    errors++;
  endtask

  task automatic check_result();
    result_t want;
    if (results_due.size() == 0) begin
      report_mismatch("result word with nothing due, kind", 0, 32'(out_if.kind));
    end else begin
      want = results_due.pop_front();
      if (out_if.kind !== want.kind)
        report_mismatch("kind", 32'(want.kind), 32'(out_if.kind));
      if (out_if.out_byte !== want.data)
        report_mismatch("out_byte", 32'(want.data), 32'($unsigned(out_if.out_byte)));
      if (out_if.ack_bit !== want.ack_bit)
        report_mismatch("ack_bit", 32'(want.ack_bit), 32'(out_if.ack_bit));
      if (out_if.run_end !== want.run_end)
        report_mismatch("run_end", 32'(want.run_end), 32'(out_if.run_end));
    end
  endtask

  // ---------------------------------------------------------------------------
  // monitor: both handshakes sampled at the rising edge, plus the watchdog
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    logic moved;
    moved = 1'b0;
    if (rst_n) begin
      if (in_if.valid && in_if.ready) begin
        predict_word(in_if.payload_byte, in_if.end_of_packet, in_if.rx_seq,
                     in_if.rx_ack, in_if.rx_check);
        moved = 1'b1;
      end
      if (out_if.valid && out_if.ready) begin
        check_result();
        moved = 1'b1;
      end
      if (moved) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: ready changes at the falling edge; a requested hold-off is counted here
  // ---------------------------------------------------------------------------
  initial begin
    int hold_left;
    int hold_seen;
    hold_left    = 0;
    hold_seen    = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_seq != hold_seen) begin
        hold_seen = hold_seq;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        case (idle_mode)
          IDLE_SINK: out_if.ready <= ($urandom_range(99) >= 86);
          IDLE_BOTH: out_if.ready <= ($urandom_range(99) >= 15);
          default:   out_if.ready <= 1'b1;
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // sender side
  // ---------------------------------------------------------------------------

  // offer one word at a falling edge and hold it until the core takes it;
  // valid stays high afterwards so back-to-back words need no bubble
  task automatic send_word(input logic [BYTE_W-1:0] b, input logic eop,
                           input logic [WORD_W-1:0] seq, input logic [WORD_W-1:0] ack,
                           input logic [WORD_W-1:0] chk);
    int pct;
    case (idle_mode)
      IDLE_SRC:  pct = 86;
      IDLE_BOTH: pct = 15;
      default:   pct = 0;
    endcase
    while ($urandom_range(99) < pct) begin
      @(negedge clk);
      in_if.valid <= 1'b0;
    end
    @(negedge clk);
    in_if.payload_byte  <= b;
    in_if.end_of_packet <= eop;
    in_if.rx_seq        <= seq;
    in_if.rx_ack        <= ack;
    in_if.rx_check      <= chk;
    in_if.valid         <= 1'b1;
    do @(posedge clk); while (!in_if.ready);
  endtask

  // one packet: header fields of the non-closing words are random junk
  task automatic send_packet(input byte_q_t bytes_in, input pkt_form_t form,
                             input logic [WORD_W-1:0] ack);
    int                n;
    logic [WORD_W-1:0] sum;
    logic [WORD_W-1:0] seq;
    logic [WORD_W-1:0] chk;
    n   = bytes_in.size();
    sum = '0;
    for (int i = 0; i < n; i++) begin
      if (i < PAYLOAD_BYTES)
        sum = sum + {{(WORD_W-BYTE_W){bytes_in[i][BYTE_W-1]}}, bytes_in[i]};
      if (i < n - 1) send_word(bytes_in[i], 1'b0, $urandom, $urandom, $urandom);
    end
    case (form)
      PKT_GOOD: begin
        seq    = {{(WORD_W-1){1'b0}}, tx_bit};
        chk    = seq + ack + sum;
        tx_bit = ~tx_bit;
      end
      PKT_BAD_CHECK: begin
        seq = {{(WORD_W-1){1'b0}}, tx_bit};
        chk = (seq + ack + sum) ^ (32'd1 << $urandom_range(WORD_W - 1));
      end
      PKT_STALE_SEQ: begin
        seq = {{(WORD_W-1){1'b0}}, ~tx_bit};
        chk = seq + ack + sum;
      end
      PKT_PURE_ACK: begin
        seq = PURE_ACK_SEQ;
        chk = ack;
      end
      default: begin
        seq = $urandom;
        if (seq <= 32'd1 || seq == PURE_ACK_SEQ) seq = 32'd2;
        chk = seq + ack + sum;
      end
    endcase
    send_word(bytes_in[n - 1], 1'b1, seq, ack, chk);
  endtask

  // mostly short good packets; some long, a few overlong, a third malformed
  task automatic send_random_packet(inout int words);
    byte_q_t   q;
    int        len;
    int        pick;
    pkt_form_t form;
    pick = $urandom_range(99);
    if (pick < 70) len = $urandom_range(6, 1);
    else if (pick < 93) len = $urandom_range(PAYLOAD_BYTES, 7);
    else len = $urandom_range(PAYLOAD_BYTES + 4, PAYLOAD_BYTES + 1);
    for (int i = 0; i < len; i++) q.push_back(BYTE_W'($urandom));
    pick = $urandom_range(99);
    if (pick < 65) form = PKT_GOOD;
    else if (pick < 75) form = PKT_BAD_CHECK;
    else if (pick < 85) form = PKT_STALE_SEQ;
    else if (pick < 92) form = PKT_PURE_ACK;
    else form = PKT_ODD_SEQ;
    send_packet(q, form, $urandom);
    words += len;
  endtask

  // drop valid, wait for every due result, then let the core settle
  task automatic finish_phase();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // single-word packets at the byte extremes, bad checksum, checksum wrap, pure ack, odd sequence
  task automatic test_directed_edges();
    byte_q_t q;
    idle_mode = IDLE_NONE;
    q = {8'h7F};
    send_packet(q, PKT_GOOD, 32'h7FFF_FFFF);
    q = {8'h80};
    send_packet(q, PKT_BAD_CHECK, 32'h8000_0000);
    q = {8'h00};
    send_packet(q, PKT_PURE_ACK, 32'hFFFF_FFFF);
    q = {8'hFF};
    send_packet(q, PKT_ODD_SEQ, 32'h0000_0000);
    finish_phase();
  endtask

  // one byte more than the store holds; the closing byte must not count
  task automatic test_overlong_packet();
    byte_q_t q;
    idle_mode = IDLE_NONE;
    for (int i = 0; i < PAYLOAD_BYTES + 1; i++) q.push_back(BYTE_W'($urandom));
    send_packet(q, PKT_GOOD, $urandom);
    finish_phase();
  endtask

  task automatic test_random_traffic(input idle_mode_t mode, input int target);
    int words;
    words     = 0;
    idle_mode = mode;
    while (words < target) send_random_packet(words);
    finish_phase();
  endtask

  // receiver holds off for a long stretch while packets keep coming
  task automatic test_output_backpressure(input int target);
    int words;
    words     = 0;
    idle_mode = IDLE_NONE;
    hold_seq++;
    while (words < target) send_random_packet(words);
    finish_phase();
  endtask

  initial begin
    rst_n               = 1'b0;
    in_if.valid         = 1'b0;
    in_if.payload_byte  = '0;
    in_if.rx_seq        = '0;
    in_if.rx_ack        = '0;
    in_if.rx_check      = '0;
    in_if.end_of_packet = 1'b0;
    rx_expect_bit       = 1'b0;
    byte_total          = '0;
    byte_cnt            = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed_edges();
    test_overlong_packet();
    test_random_traffic(IDLE_NONE, 55);
    test_random_traffic(IDLE_SRC, 55);
    test_random_traffic(IDLE_SINK, 55);
    test_random_traffic(IDLE_BOTH, 55);
    test_output_backpressure(40);

    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/abr_pkg.sv
hw/rtl/abr_in_if.sv
hw/rtl/abr_out_if.sv
hw/rtl/abr_ctrl.sv
hw/rtl/abr_datapath.sv
hw/rtl/alternating_bit_receiver_core.sv
dv/tb_top.sv
